>>> design/triangle_tangent_setup_defines.svh
// ----------------------------------------------------------------------------
// Triangle tangent setup - assertion macros
// Concurrent checks clocked on clk_i, held off while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_TANGENT_SETUP_DEFINES_SVH
`define TRIANGLE_TANGENT_SETUP_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define TTS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("triangle_tangent_setup: check failed");
`define TTS_NEVER(lbl, cond) \
  `TTS_ASSERT(lbl, !(cond))
`else
`define TTS_ASSERT(lbl, prop)
`define TTS_NEVER(lbl, cond)
`endif

`endif

>>> design/tts_pkg.sv
// ----------------------------------------------------------------------------
// Triangle tangent setup - package
// Widths, record types and helpers shared by the datapath and the divider.
// ----------------------------------------------------------------------------
package tts_pkg;

  localparam int VERTEX_DEPTH = 4096;
  localparam int FRAC_BITS    = 16;

  localparam int INDEX_W = 12;
  localparam int ADDR_W  = $clog2(VERTEX_DEPTH);
  localparam int DATA_W  = 32;
  localparam int DELTA_W = DATA_W + 1;
  localparam int PROD_W  = 2 * DELTA_W;
  localparam int WIDE_W  = PROD_W + 2;
  localparam int QBITS   = DATA_W + 1;
  localparam int NUM_W   = WIDE_W + FRAC_BITS;
  localparam int CMP_W   = WIDE_W + QBITS;

  localparam int FIFO_DEPTH = 32;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_TRI   = 1'b1;

  localparam logic [DATA_W-1:0] SAT_POS = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] SAT_NEG = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic [1:0] {COMP_X, COMP_Y, COMP_Z} comp_e;

  typedef struct packed {
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] y;
    logic signed [DATA_W-1:0] z;
    logic signed [DATA_W-1:0] u;
    logic signed [DATA_W-1:0] v;
  } vtx_t;

  typedef struct packed {
    logic              valid;
    logic [WIDE_W-1:0] num;
    logic [WIDE_W-1:0] den;
    logic              neg;
    comp_e             comp;
    logic              degen;
  } div_in_t;

  typedef struct packed {
    logic             valid;
    logic [QBITS-1:0] quo;
    logic             ovf;
    logic             neg;
    comp_e            comp;
    logic             degen;
  } div_out_t;

  typedef struct packed {
    logic [DATA_W-1:0] tx;
    logic [DATA_W-1:0] ty;
    logic [DATA_W-1:0] tz;
    logic              degen;
    logic              clip;
  } res_t;

  function automatic logic in_range(input logic [INDEX_W-1:0] idx);
    return 32'(idx) < VERTEX_DEPTH;
  endfunction

  function automatic logic signed [DELTA_W-1:0] delta(
    input logic signed [DATA_W-1:0] base,
    input logic signed [DATA_W-1:0] tip
  );
    return DELTA_W'(tip) - DELTA_W'(base);
  endfunction

endpackage

>>> design/tts_div.sv
// ----------------------------------------------------------------------------
// Triangle tangent setup - pipelined divider
// Restoring division, one quotient bit per stage, numerator pre-scaled by
// the fraction bits. Flags a quotient too large for the quotient field.
// ----------------------------------------------------------------------------
module tts_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tts_pkg::div_in_t   in_i,
  output tts_pkg::div_out_t  out_o
);

  localparam int QB = tts_pkg::QBITS;

  logic [QB:0]                  v_q;
  logic [tts_pkg::NUM_W-1:0]    r_q  [QB];
  logic [tts_pkg::WIDE_W-1:0]   d_q  [QB];
  logic [QB-1:0]                qo_q [QB+1];
  logic [QB:0]                  ovf_q;
  logic [QB:0]                  neg_q;
  logic [QB:0]                  dg_q;
  tts_pkg::comp_e               cp_q [QB+1];

  logic [tts_pkg::NUM_W-1:0] num_sh;
  logic                      ovf_in;

  assign num_sh = {in_i.num, {tts_pkg::FRAC_BITS{1'b0}}};
  assign ovf_in = tts_pkg::CMP_W'(num_sh) >= (tts_pkg::CMP_W'(in_i.den) << QB);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else begin
      v_q[0] <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q[0]   <= num_sh;
    d_q[0]   <= in_i.den;
    qo_q[0]  <= '0;
    ovf_q[0] <= ovf_in;
    neg_q[0] <= in_i.neg;
    dg_q[0]  <= in_i.degen;
    cp_q[0]  <= in_i.comp;
  end

  for (genvar s = 0; s < QB; s++) begin : g_stage
    logic [tts_pkg::CMP_W-1:0] rem_w;
    logic [tts_pkg::CMP_W-1:0] sub_w;
    logic                      ge;

    assign sub_w = tts_pkg::CMP_W'(d_q[s]) << (QB - 1 - s);
    assign rem_w = tts_pkg::CMP_W'(r_q[s]);
    assign ge    = rem_w >= sub_w;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s+1] <= 1'b0;
      end else begin
        v_q[s+1] <= v_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      qo_q[s+1]  <= {qo_q[s][QB-2:0], ge};
      ovf_q[s+1] <= ovf_q[s];
      neg_q[s+1] <= neg_q[s];
      dg_q[s+1]  <= dg_q[s];
      cp_q[s+1]  <= cp_q[s];
    end

    if (s < QB - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        r_q[s+1] <= ge ? tts_pkg::NUM_W'(rem_w - sub_w) : r_q[s];
        d_q[s+1] <= d_q[s];
      end
    end
  end

  assign out_o.valid = v_q[QB];
  assign out_o.quo   = qo_q[QB];
  assign out_o.ovf   = ovf_q[QB];
  assign out_o.neg   = neg_q[QB];
  assign out_o.comp  = cp_q[QB];
  assign out_o.degen = dg_q[QB];

endmodule

>>> design/triangle_tangent_setup.sv
// ----------------------------------------------------------------------------
// Triangle tangent setup - top level
// Vertex store plus per-triangle tangent datapath with a result queue.
// ----------------------------------------------------------------------------
// One input channel (in_valid_i/in_ready_o) carries two kinds of beat: a
// vertex write stores position and UV at vertex_index_i and gives no result;
// a triangle beat reads corners a, b, c and gives one result beat on the
// output channel (out_valid_o/out_ready_i), in order.
// Store port: a vertex write uses it only in the cycle it is accepted; a
// triangle makes one read per corner on the single-ported vertex RAM and
// holds off further input until its last corner has been read.
// The three tangent components pass one per cycle through the 34-stage
// divider on their way from triangle acceptance to out_valid_o.
// Results wait in a 32-entry queue; input is held off once 32 triangles are
// outstanding, so a stalled receiver stops the input after that many and
// nothing is dropped. Reset empties the queue and pipeline; the vertex store
// is not cleared and must be written before it is read.
// ----------------------------------------------------------------------------
`include "triangle_tangent_setup_defines.svh"

module triangle_tangent_setup (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                req_type_i,
  input  logic        [tts_pkg::INDEX_W-1:0]  vertex_index_i,
  input  logic signed [tts_pkg::DATA_W-1:0]   pos_x_i,
  input  logic signed [tts_pkg::DATA_W-1:0]   pos_y_i,
  input  logic signed [tts_pkg::DATA_W-1:0]   pos_z_i,
  input  logic signed [tts_pkg::DATA_W-1:0]   tex_u_i,
  input  logic signed [tts_pkg::DATA_W-1:0]   tex_v_i,
  input  logic        [tts_pkg::INDEX_W-1:0]  corner_a_i,
  input  logic        [tts_pkg::INDEX_W-1:0]  corner_b_i,
  input  logic        [tts_pkg::INDEX_W-1:0]  corner_c_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [tts_pkg::DATA_W-1:0]   tangent_x_o,
  output logic signed [tts_pkg::DATA_W-1:0]   tangent_y_o,
  output logic signed [tts_pkg::DATA_W-1:0]   tangent_z_o,
  output logic                                degenerate_o,
  output logic                                clipped_o
);

  typedef enum logic [1:0] {PH_IDLE, PH_B, PH_C} ph_e;
  typedef enum logic [1:0] {CRN_A, CRN_B, CRN_C} crn_e;

  localparam int CW = tts_pkg::FIFO_AW + 1;
  localparam logic [CW-1:0] CRED_MAX = CW'(tts_pkg::FIFO_DEPTH);

  // front end and vertex store
  ph_e                            ph_q;
  logic                           rt_v_q;
  crn_e                           rt_sel_q;
  logic                           rt_oor_q;
  logic [tts_pkg::INDEX_W-1:0]    cb_q, cc_q;
  logic                           in_acc, tri_acc, wr_acc;
  logic                           rd_en, wr_en;
  logic [tts_pkg::INDEX_W-1:0]    rd_idx, mem_idx;
  logic [tts_pkg::ADDR_W-1:0]     mem_addr;
  crn_e                           rd_sel;
  tts_pkg::vtx_t                  vtx_mem [tts_pkg::VERTEX_DEPTH];
  tts_pkg::vtx_t                  rdata_q, wdata, cdat;

  logic [CW-1:0]                  cred_q;

  assign in_ready_o = (ph_q == PH_IDLE) && (cred_q < CRED_MAX);
  assign in_acc     = in_valid_i && in_ready_o;
  assign tri_acc    = in_acc && (req_type_i == tts_pkg::REQ_TRI);
  assign wr_acc     = in_acc && (req_type_i == tts_pkg::REQ_WRITE);
  assign wr_en      = wr_acc && tts_pkg::in_range(vertex_index_i);

  always_comb begin
    unique case (ph_q)
      PH_IDLE: begin
        rd_en  = tri_acc;
        rd_idx = corner_a_i;
        rd_sel = CRN_A;
      end
      PH_B: begin
        rd_en  = 1'b1;
        rd_idx = cb_q;
        rd_sel = CRN_B;
      end
      default: begin
        rd_en  = 1'b1;
        rd_idx = cc_q;
        rd_sel = CRN_C;
      end
    endcase
  end

  assign mem_idx  = wr_acc ? vertex_index_i : rd_idx;
  assign mem_addr = tts_pkg::ADDR_W'(mem_idx);
  assign wdata    = '{x: pos_x_i, y: pos_y_i, z: pos_z_i, u: tex_u_i, v: tex_v_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q     <= PH_IDLE;
      rt_v_q   <= 1'b0;
      rt_sel_q <= CRN_A;
      rt_oor_q <= 1'b0;
    end else begin
      rt_v_q   <= rd_en;
      rt_sel_q <= rd_sel;
      rt_oor_q <= !tts_pkg::in_range(rd_idx);
      unique case (ph_q)
        PH_IDLE: if (tri_acc) ph_q <= PH_B;
        PH_B:    ph_q <= PH_C;
        default: ph_q <= PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (tri_acc) begin
      cb_q <= corner_b_i;
      cc_q <= corner_c_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) vtx_mem[mem_addr] <= wdata;
    if (rd_en) rdata_q <= vtx_mem[mem_addr];
  end

  assign cdat = rt_oor_q ? '0 : rdata_q;

  // corner capture and deltas
  tts_pkg::vtx_t                     va_q, vb_q;
  logic                              dl_v_q;
  logic signed [tts_pkg::DELTA_W-1:0] p1_q [3];
  logic signed [tts_pkg::DELTA_W-1:0] p2_q [3];
  logic signed [tts_pkg::DELTA_W-1:0] s1_q, s2_q, t1_q, t2_q;

  always_ff @(posedge clk_i) begin
    if (rt_v_q) begin
      unique case (rt_sel_q)
        CRN_A: va_q <= cdat;
        CRN_B: vb_q <= cdat;
        CRN_C: begin
          p1_q[0] <= tts_pkg::delta(va_q.x, vb_q.x);
          p1_q[1] <= tts_pkg::delta(va_q.y, vb_q.y);
          p1_q[2] <= tts_pkg::delta(va_q.z, vb_q.z);
          p2_q[0] <= tts_pkg::delta(va_q.x, cdat.x);
          p2_q[1] <= tts_pkg::delta(va_q.y, cdat.y);
          p2_q[2] <= tts_pkg::delta(va_q.z, cdat.z);
          s1_q    <= tts_pkg::delta(va_q.u, vb_q.u);
          s2_q    <= tts_pkg::delta(va_q.u, cdat.u);
          t1_q    <= tts_pkg::delta(va_q.v, vb_q.v);
          t2_q    <= tts_pkg::delta(va_q.v, cdat.v);
        end
        default: ;
      endcase
    end
  end

  // products, differences, magnitudes
  logic                               pr_v_q, wd_v_q, mg_v_q;
  logic signed [tts_pkg::PROD_W-1:0]  pd_a_q, pd_b_q;
  logic signed [tts_pkg::PROD_W-1:0]  pn_a_q [3];
  logic signed [tts_pkg::PROD_W-1:0]  pn_b_q [3];
  logic signed [tts_pkg::WIDE_W-1:0]  det_q;
  logic signed [tts_pkg::WIDE_W-1:0]  num_q [3];
  logic        [tts_pkg::WIDE_W-1:0]  dmag_q;
  logic        [tts_pkg::WIDE_W-1:0]  nmag_q [3];
  logic                               dneg_q, dzero_q;
  logic                               nneg_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dl_v_q <= 1'b0;
      pr_v_q <= 1'b0;
      wd_v_q <= 1'b0;
      mg_v_q <= 1'b0;
    end else begin
      dl_v_q <= rt_v_q && (rt_sel_q == CRN_C);
      pr_v_q <= dl_v_q;
      wd_v_q <= pr_v_q;
      mg_v_q <= wd_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    pd_a_q <= s1_q * t2_q;
    pd_b_q <= s2_q * t1_q;
    det_q  <= tts_pkg::WIDE_W'(pd_a_q) - tts_pkg::WIDE_W'(pd_b_q);
    dmag_q  <= det_q[tts_pkg::WIDE_W-1] ? -det_q : det_q;
    dneg_q  <= det_q[tts_pkg::WIDE_W-1];
    dzero_q <= (det_q == '0);
    for (int k = 0; k < 3; k++) begin
      pn_a_q[k] <= t2_q * p1_q[k];
      pn_b_q[k] <= t1_q * p2_q[k];
      num_q[k]  <= tts_pkg::WIDE_W'(pn_a_q[k]) - tts_pkg::WIDE_W'(pn_b_q[k]);
      nmag_q[k] <= num_q[k][tts_pkg::WIDE_W-1] ? -num_q[k] : num_q[k];
      nneg_q[k] <= num_q[k][tts_pkg::WIDE_W-1];
    end
  end

  // one component per cycle into the divider
  tts_pkg::comp_e    sc_q, cur;
  tts_pkg::div_in_t  div_in;
  tts_pkg::div_out_t div_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sc_q <= tts_pkg::COMP_X;
    end else if (mg_v_q) begin
      sc_q <= tts_pkg::COMP_Y;
    end else if (sc_q == tts_pkg::COMP_Y) begin
      sc_q <= tts_pkg::COMP_Z;
    end else begin
      sc_q <= tts_pkg::COMP_X;
    end
  end

  assign cur          = mg_v_q ? tts_pkg::COMP_X : sc_q;
  assign div_in.valid = mg_v_q || (sc_q != tts_pkg::COMP_X);
  assign div_in.num   = nmag_q[cur];
  assign div_in.den   = dmag_q;
  assign div_in.neg   = nneg_q[cur] ^ dneg_q;
  assign div_in.comp  = cur;
  assign div_in.degen = dzero_q;

  tts_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (div_in),
    .out_o (div_out)
  );

  // saturation and result assembly
  logic [tts_pkg::DATA_W-1:0] sval;
  logic                       sclip;
  logic [tts_pkg::QBITS-1:0]  nq;
  logic [tts_pkg::DATA_W-1:0] rx_q, ry_q;
  logic                       cx_q, cy_q;
  logic                       push, pop;

  assign nq = -div_out.quo;

  always_comb begin
    sval  = '0;
    sclip = 1'b0;
    priority if (div_out.degen) begin
      sval = '0;
    end else if (div_out.neg) begin
      if (div_out.ovf || (div_out.quo > {1'b0, tts_pkg::SAT_NEG})) begin
        sval  = tts_pkg::SAT_NEG;
        sclip = 1'b1;
      end else begin
        sval = nq[tts_pkg::DATA_W-1:0];
      end
    end else begin
      if (div_out.ovf || (div_out.quo > {1'b0, tts_pkg::SAT_POS})) begin
        sval  = tts_pkg::SAT_POS;
        sclip = 1'b1;
      end else begin
        sval = div_out.quo[tts_pkg::DATA_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_out.valid) begin
      unique case (div_out.comp)
        tts_pkg::COMP_X: begin
          rx_q <= sval;
          cx_q <= sclip;
        end
        tts_pkg::COMP_Y: begin
          ry_q <= sval;
          cy_q <= sclip;
        end
        default: ;
      endcase
    end
  end

  assign push = div_out.valid && (div_out.comp == tts_pkg::COMP_Z);

  // result queue
  tts_pkg::res_t              fifo_q [tts_pkg::FIFO_DEPTH];
  tts_pkg::res_t              head;
  logic [tts_pkg::FIFO_AW-1:0] wp_q, rp_q;
  logic [CW-1:0]              cnt_q;

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wp_q] <= '{tx: rx_q, ty: ry_q, tz: sval, degen: div_out.degen,
                        clip: cx_q | cy_q | sclip};
    end
  end

  assign head        = fifo_q[rp_q];
  assign out_valid_o = (cnt_q != '0);
  assign pop         = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= '0;
      rp_q   <= '0;
      cnt_q  <= '0;
      cred_q <= '0;
    end else begin
      if (push) wp_q <= wp_q + 1'b1;
      if (pop)  rp_q <= rp_q + 1'b1;
      cnt_q  <= cnt_q + CW'(push) - CW'(pop);
      cred_q <= cred_q + CW'(tri_acc) - CW'(pop);
    end
  end

  assign tangent_x_o  = head.tx;
  assign tangent_y_o  = head.ty;
  assign tangent_z_o  = head.tz;
  assign degenerate_o = head.degen;
  assign clipped_o    = head.clip;

  // checks
  `TTS_NEVER(a_cred_bound, cred_q > CRED_MAX)
  `TTS_NEVER(a_fifo_overrun, push && (cnt_q == CRED_MAX) && !pop)
  `TTS_ASSERT(a_read_seq, tri_acc |=> (ph_q == PH_B) && rt_v_q && (rt_sel_q == CRN_A))
  `TTS_ASSERT(a_comp_order, (div_out.valid && div_out.comp == tts_pkg::COMP_Z) |-> $past(div_out.valid && div_out.comp == tts_pkg::COMP_Y))

endmodule
